[rtl/ccks_pkg.sv]
package ccks_pkg;

  // set mode codes
  localparam logic [2:0] MODE_RUN    = 3'd0;
  localparam logic [2:0] MODE_MONTH  = 3'd1;
  localparam logic [2:0] MODE_DAY    = 3'd2;
  localparam logic [2:0] MODE_YEAR   = 3'd3;
  localparam logic [2:0] MODE_HOUR   = 3'd4;
  localparam logic [2:0] MODE_MINUTE = 3'd5;

  // transaction kinds carried in tuser
  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_KEY  = 1'b1;

  // key codes
  localparam logic [2:0] KEY_NEXT = 3'd1;
  localparam logic [2:0] KEY_UP   = 3'd2;
  localparam logic [2:0] KEY_DOWN = 3'd3;
  localparam logic [2:0] KEY_SET  = 3'd4;

  // counter limits and reset values
  localparam logic [13:0] YEAR_LAST    = 14'd9999;
  localparam logic [13:0] YEAR_RESET   = 14'd2019;
  localparam logic [5:0]  SEC_LAST     = 6'd59;
  localparam logic [5:0]  MIN_LAST     = 6'd59;
  localparam logic [4:0]  HOUR_LAST    = 5'd23;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [7:0]  TPS_RESET    = 8'd10;

  // widths of the transaction data
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 56;

  // clock and calendar state
  typedef struct packed {
    logic [7:0]  tick_count;
    logic [5:0]  seconds;
    logic [5:0]  minutes;
    logic [4:0]  hours;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [2:0]  mode;
  } ccks_state_t;

  // input stage to update logic
  typedef struct packed {
    logic       valid;
    logic       cmd;
    logic [2:0] key;
  } ccks_item_t;

endpackage

[rtl/calendar_clock_with_key_setting.sv]
// Calendar clock with key setting. Each input transaction is either a time
// tick (tuser 0) or a key event (tuser 1, key code in tdata), and each one
// produces exactly one output transaction holding a snapshot of month, day,
// year, hour, minute, second, tick count and set mode after that item. Ticks
// advance the clock every ticks_per_second ticks (written through the
// configuration port, reset 10) unless set mode is active. The block takes one
// transaction per clock cycle while the output is not stalled; an accepted item
// waits in the input register and then passes through the combinational update
// logic into the output register, and backpressure on the output stalls the
// input only once both registers are full.
module calendar_clock_with_key_setting (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [7:0]                      cfg_wr_data,  // ticks_per_second
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic                            s_tuser,      // cmd
  input  logic [ccks_pkg::IN_DATA_W-1:0]  s_tdata,      // key [2:0]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // month_out [3:0], day_out [8:4], year_out [22:9], hour_out [27:23],
  // minute_out [33:28], second_out [39:34], tick_count_out [47:40],
  // mode_out [50:48], zero fill above
  output logic [ccks_pkg::OUT_DATA_W-1:0] m_tdata
);
  import ccks_pkg::*;

  logic        take;
  ccks_item_t  item;
  ccks_state_t state;
  ccks_state_t state_next;
  logic [7:0]  ticks_per_second;

  // process the held item when the output register can take its result
  assign take = item.valid && (!m_tvalid || m_tready);

  ccks_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .take     (take),
    .item     (item)
  );

  ccks_update u_update (
    .cur              (state),
    .cmd              (item.cmd),
    .key              (item.key),
    .ticks_per_second (ticks_per_second),
    .nxt              (state_next)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (cfg_wr_en) begin
      ticks_per_second <= cfg_wr_data;
    end
  end

  // clock state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.tick_count <= 8'd0;
      state.seconds    <= 6'd0;
      state.minutes    <= 6'd0;
      state.hours      <= 5'd0;
      state.day        <= 5'd1;
      state.month      <= 4'd1;
      state.year       <= YEAR_RESET;
      state.mode       <= MODE_RUN;
    end else if (take) begin
      state <= state_next;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // output register data
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= {5'd0, state_next.mode, state_next.tick_count, state_next.seconds,
                  state_next.minutes, state_next.hours, state_next.year,
                  state_next.day, state_next.month};
    end
  end

endmodule

[rtl/ccks_in_stage.sv]
module ccks_in_stage (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic                          s_tuser,  // cmd
  input  logic [ccks_pkg::IN_DATA_W-1:0] s_tdata, // key [2:0], zero fill above
  input  logic                          take,
  output ccks_pkg::ccks_item_t          item
);
  import ccks_pkg::*;

  ccks_item_t item_next;

  // register is free when empty or being consumed this cycle
  assign s_tready = !item.valid || take;

  // load a new transaction or drain the held one
  always_comb begin
    item_next = item;
    if (s_tvalid && s_tready) begin
      item_next.valid = 1'b1;
      item_next.cmd   = s_tuser;
      item_next.key   = s_tdata[2:0];
    end else if (take) begin
      item_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      item <= '0;
    end else begin
      item <= item_next;
    end
  end

endmodule

[rtl/ccks_update.sv]
module ccks_update (
  input  ccks_pkg::ccks_state_t cur,
  input  logic                  cmd,
  input  logic [2:0]            key,
  input  logic [7:0]            ticks_per_second,
  output ccks_pkg::ccks_state_t nxt
);
  import ccks_pkg::*;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // month length, leap february when year is a nonzero multiple of four
  function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [13:0] y);
    logic [3:0] mi;
    logic [4:0] n;
    mi = (m < 4'd1 || m > MONTH_LAST) ? 4'd0 : m - 4'd1;
    n  = MONTH_LEN[mi];
    if (m == 4'd2 && y != 14'd0 && y[1:0] == 2'b00) n = 5'd29;
    return n;
  endfunction

  // step up or down between lo and hi with wrap
  function automatic logic [13:0] step_wrap(input logic [13:0] v, input logic [13:0] lo,
                                            input logic [13:0] hi, input logic up);
    logic [13:0] r;
    if (up) r = (v >= hi) ? lo : v + 14'd1;
    else    r = (v <= lo) ? hi : v - 14'd1;
    return r;
  endfunction

  logic [8:0]  tick_inc;
  logic [5:0]  day_inc;
  logic [4:0]  dim_cur;
  logic [4:0]  dim_new;
  logic        up;
  logic [13:0] stepped;
  ccks_state_t keyed;

  assign tick_inc = {1'b0, cur.tick_count} + 9'd1;
  assign day_inc  = {1'b0, cur.day} + 6'd1;
  assign dim_cur  = days_in_month(cur.month, cur.year);
  assign up       = (key == KEY_UP);

  // field step in set mode
  always_comb begin
    case (cur.mode)
      MODE_MONTH: stepped = step_wrap({10'd0, cur.month}, 14'd1, {10'd0, MONTH_LAST}, up);
      MODE_DAY:   stepped = step_wrap({9'd0, cur.day}, 14'd1, {9'd0, dim_cur}, up);
      MODE_YEAR:  stepped = step_wrap(cur.year, 14'd0, YEAR_LAST, up);
      MODE_HOUR:  stepped = step_wrap({9'd0, cur.hours}, 14'd0, {9'd0, HOUR_LAST}, up);
      default:    stepped = step_wrap({8'd0, cur.minutes}, 14'd0, {8'd0, MIN_LAST}, up);
    endcase
  end

  // key handling before the day check
  always_comb begin
    keyed = cur;
    if (cur.mode == MODE_RUN) begin
      if (key == KEY_SET) keyed.mode = MODE_MONTH;
    end else if (key == KEY_SET) begin
      keyed.mode = MODE_RUN;
    end else if (key == KEY_NEXT) begin
      keyed.mode = (cur.mode >= MODE_MINUTE) ? MODE_MONTH : cur.mode + 3'd1;
    end else if (key == KEY_UP || key == KEY_DOWN) begin
      case (cur.mode)
        MODE_MONTH: keyed.month   = stepped[3:0];
        MODE_DAY:   keyed.day     = stepped[4:0];
        MODE_YEAR:  keyed.year    = stepped;
        MODE_HOUR:  keyed.hours   = stepped[4:0];
        default:    keyed.minutes = stepped[5:0];
      endcase
    end
  end

  assign dim_new = days_in_month(keyed.month, keyed.year);

  // tick cascade or key result with day check
  always_comb begin
    nxt = cur;
    if (cmd == CMD_TICK) begin
      if (cur.mode == MODE_RUN) begin
        if (tick_inc < {1'b0, ticks_per_second}) begin
          nxt.tick_count = tick_inc[7:0];
        end else begin
          nxt.tick_count = 8'd0;
          if (cur.seconds < SEC_LAST) begin
            nxt.seconds = cur.seconds + 6'd1;
          end else begin
            nxt.seconds = 6'd0;
            if (cur.minutes < MIN_LAST) begin
              nxt.minutes = cur.minutes + 6'd1;
            end else begin
              nxt.minutes = 6'd0;
              if (cur.hours < HOUR_LAST) begin
                nxt.hours = cur.hours + 5'd1;
              end else begin
                nxt.hours = 5'd0;
                if (day_inc <= {1'b0, dim_cur}) begin
                  nxt.day = day_inc[4:0];
                end else begin
                  nxt.day = 5'd1;
                  if (cur.month < MONTH_LAST) begin
                    nxt.month = cur.month + 4'd1;
                  end else begin
                    nxt.month = 4'd1;
                    nxt.year  = (cur.year >= YEAR_LAST) ? 14'd0 : cur.year + 14'd1;
                  end
                end
              end
            end
          end
        end
      end
    end else begin
      nxt = keyed;
      if (keyed.day > dim_new || keyed.day < 5'd1) nxt.day = 5'd1;
    end
  end

endmodule

[tb/tb_calendar_clock_with_key_setting.sv]
module tb_calendar_clock_with_key_setting;
  import ccks_pkg::*;

  localparam int STALL_CYCLES   = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int MAX_REPORTS    = 10;

  // key codes with no function in the block
  localparam logic [2:0] KEY_NONE   = 3'd0;
  localparam logic [2:0] KEY_SPARE5 = 3'd5;
  localparam logic [2:0] KEY_SPARE6 = 3'd6;
  localparam logic [2:0] KEY_SPARE7 = 3'd7;

  // result fields as packed in m_tdata, highest bits first
  typedef struct packed {
    logic [4:0]  fill;
    logic [2:0]  mode;
    logic [7:0]  tick_count;
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [4:0]  hour;
    logic [13:0] year;
    logic [4:0]  day;
    logic [3:0]  month;
  } clock_view_t;

  logic                  clk         = 1'b0;
  logic                  rst         = 1'b1;
  logic                  cfg_wr_en   = 1'b0;
  logic [7:0]            cfg_wr_data = 8'd0;
  logic                  s_tvalid    = 1'b0;
  logic                  s_tready;
  logic                  s_tuser     = CMD_TICK;  // cmd
  logic [IN_DATA_W-1:0]  s_tdata     = '0;        // key
  logic                  m_tvalid;
  logic                  m_tready    = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  // expected clock state, updated as each transaction is accepted
  int         cal_tps   = TPS_RESET;
  int         cal_tick  = 0;
  int         cal_sec   = 0;
  int         cal_min   = 0;
  int         cal_hour  = 0;
  int         cal_day   = 1;
  int         cal_month = 1;
  int         cal_year  = YEAR_RESET;
  logic [2:0] cal_mode  = MODE_RUN;

  clock_view_t view_q[$];

  int error_count     = 0;
  int items_sent      = 0;
  int tick_items      = 0;
  int key_items       = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int send_idle_pct   = 0;
  int recv_idle_pct   = 0;
  int quiet_cycles    = 0;
  int hold_left       = 0;
  logic stall_req     = 1'b0;
  logic stall_ack     = 1'b0;

  calendar_clock_with_key_setting dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

  always #5 clk = ~clk;

  // calendar arithmetic
  function automatic int month_length(input int month, input int year);
    int len;
    case (month)
      2: len = (year != 0 && year % 4 == 0) ? 29 : 28;
      4, 6, 9, 11: len = 30;
      default: len = 31;
    endcase
    return len;
  endfunction

  function automatic int wrap_step(input int value, input int lo, input int hi, input logic up);
    if (up) return (value >= hi) ? lo : value + 1;
    return (value <= lo) ? hi : value - 1;
  endfunction

  // one tick through the counter cascade
  function automatic void advance_tick();
    cal_tick++;
    if (cal_tick < cal_tps) return;
    cal_tick = 0;
    cal_sec++;
    if (cal_sec <= SEC_LAST) return;
    cal_sec = 0;
    cal_min++;
    if (cal_min <= MIN_LAST) return;
    cal_min = 0;
    cal_hour++;
    if (cal_hour <= HOUR_LAST) return;
    cal_hour = 0;
    cal_day++;
    if (cal_day <= month_length(cal_month, cal_year)) return;
    cal_day = 1;
    cal_month++;
    if (cal_month <= MONTH_LAST) return;
    cal_month = 1;
    cal_year = (cal_year >= YEAR_LAST) ? 0 : cal_year + 1;
  endfunction

  // key handling, then the day clamp that follows every key
  function automatic void apply_key(input logic [2:0] key);
    logic up;
    up = (key == KEY_UP);
    if (cal_mode == MODE_RUN) begin
      if (key == KEY_SET) cal_mode = MODE_MONTH;
    end else if (key == KEY_SET) begin
      cal_mode = MODE_RUN;
    end else if (key == KEY_NEXT) begin
      cal_mode = (cal_mode >= MODE_MINUTE) ? MODE_MONTH : cal_mode + 3'd1;
    end else if (key == KEY_UP || key == KEY_DOWN) begin
      case (cal_mode)
        MODE_MONTH: cal_month = wrap_step(cal_month, 1, MONTH_LAST, up);
        MODE_DAY: cal_day = wrap_step(cal_day, 1, month_length(cal_month, cal_year), up);
        MODE_YEAR: cal_year = wrap_step(cal_year, 0, YEAR_LAST, up);
        MODE_HOUR: cal_hour = wrap_step(cal_hour, 0, HOUR_LAST, up);
        default: cal_min = wrap_step(cal_min, 0, MIN_LAST, up);
      endcase
    end
    if (cal_day > month_length(cal_month, cal_year) || cal_day < 1) cal_day = 1;
  endfunction

  function automatic clock_view_t current_view();
    clock_view_t v;
    v = '0;
    v.month      = 4'(cal_month);
    v.day        = 5'(cal_day);
    v.year       = 14'(cal_year);
    v.hour       = 5'(cal_hour);
    v.minute     = 6'(cal_min);
    v.second     = 6'(cal_sec);
    v.tick_count = 8'(cal_tick);
    v.mode       = cal_mode;
    return v;
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  // compare one output transaction with the oldest expected view
  function automatic void check_result(input clock_view_t got);
    clock_view_t want;
    results_checked++;
    if (view_q.size() == 0) begin
      flag_error($sformatf("result with nothing expected: %h", got));
      return;
    end
    want = view_q.pop_front();
    if (got.month != want.month)
      flag_error($sformatf("month: expected %0d, got %0d", want.month, got.month));
    if (got.day != want.day)
      flag_error($sformatf("day: expected %0d, got %0d", want.day, got.day));
    if (got.year != want.year)
      flag_error($sformatf("year: expected %0d, got %0d", want.year, got.year));
    if (got.hour != want.hour)
      flag_error($sformatf("hour: expected %0d, got %0d", want.hour, got.hour));
    if (got.minute != want.minute)
      flag_error($sformatf("minute: expected %0d, got %0d", want.minute, got.minute));
    if (got.second != want.second)
      flag_error($sformatf("second: expected %0d, got %0d", want.second, got.second));
    if (got.tick_count != want.tick_count)
      flag_error($sformatf("tick count: expected %0d, got %0d",
                           want.tick_count, got.tick_count));
    if (got.mode != want.mode)
      flag_error($sformatf("mode: expected %0d, got %0d", want.mode, got.mode));
  endfunction

  function automatic logic [2:0] any_key();
    return 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [2:0] pick_setting_key();
    case ($urandom_range(9))
      0, 1: return KEY_NEXT;
      2, 3, 4: return KEY_UP;
      5, 6, 7: return KEY_DOWN;
      8: return KEY_SET;
      default: return any_key();
    endcase
  endfunction

  function automatic logic [7:0] pick_tps();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(1, 255));
      default: return 8'($urandom_range(1, 3));
    endcase
  endfunction

  // receiver: checks results, random ready, long hold-off on request
  always @(posedge clk) begin
    if (m_tvalid && m_tready) check_result(clock_view_t'(m_tdata));
    if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      hold_left <= STALL_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction in %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one item, record its expected view once accepted
  task automatic send_item(input logic cmd, input logic [2:0] key);
    s_tuser  <= cmd;
    s_tdata  <= IN_DATA_W'(key);
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (cmd == CMD_TICK) begin
      if (cal_mode == MODE_RUN) advance_tick();
      tick_items++;
    end else begin
      apply_key(key);
      key_items++;
    end
    items_sent++;
    view_q.push_back(current_view());
    // each idle cycle drawn on its own so the idle share matches the setting
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // register write once the block has drained
  task automatic set_ticks_per_second(input logic [7:0] value);
    s_tvalid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_data <= value;
    cfg_wr_en   <= 1'b1;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cal_tps = value;
    cfg_writes++;
  endtask

  task automatic select_field(input logic [2:0] field);
    if (cal_mode == MODE_RUN) send_item(CMD_KEY, KEY_SET);
    while (cal_mode != field) send_item(CMD_KEY, KEY_NEXT);
  endtask

  task automatic leave_setting();
    if (cal_mode != MODE_RUN) send_item(CMD_KEY, KEY_SET);
  endtask

  // step the selected field to a target the short way round
  task automatic walk_to(input int cur, input int target, input int lo, input int hi);
    int span;
    int up_steps;
    span = hi - lo + 1;
    up_steps = ((target - cur) % span + span) % span;
    if (up_steps <= span / 2) repeat (up_steps) send_item(CMD_KEY, KEY_UP);
    else repeat (span - up_steps) send_item(CMD_KEY, KEY_DOWN);
  endtask

  // set all fields by keys, day clipped to the month, then run again
  task automatic set_clock(input int month, input int day, input int year,
                           input int hour, input int minute);
    int len;
    select_field(MODE_MONTH);
    walk_to(cal_month, month, 1, MONTH_LAST);
    select_field(MODE_DAY);
    len = month_length(cal_month, cal_year);
    walk_to(cal_day, (day > len) ? len : day, 1, len);
    select_field(MODE_YEAR);
    walk_to(cal_year, year, 0, YEAR_LAST);
    select_field(MODE_HOUR);
    walk_to(cal_hour, hour, 0, HOUR_LAST);
    select_field(MODE_MINUTE);
    walk_to(cal_min, minute, 0, MIN_LAST);
    leave_setting();
  endtask

  task automatic tick_past_minute();
    int start_minute;
    start_minute = cal_min;
    while (cal_min == start_minute) send_item(CMD_TICK, any_key());
  endtask

  task automatic test_keys_while_running();
    send_item(CMD_KEY, KEY_NEXT);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_NONE);
    send_item(CMD_KEY, KEY_SPARE5);
    send_item(CMD_KEY, KEY_SPARE6);
    send_item(CMD_KEY, KEY_SPARE7);
    send_item(CMD_TICK, KEY_SPARE7);
  endtask

  task automatic test_second_boundary();
    repeat (9) send_item(CMD_TICK, any_key());
    set_ticks_per_second(8'd255);
    repeat (5) send_item(CMD_TICK, any_key());
    // count already past the new rate ends the second at once
    set_ticks_per_second(8'd3);
    send_item(CMD_TICK, any_key());
    set_ticks_per_second(8'd0);
    repeat (2) send_item(CMD_TICK, any_key());
    set_ticks_per_second(8'd1);
    send_item(CMD_TICK, any_key());
  endtask

  task automatic test_field_stepping();
    send_item(CMD_KEY, KEY_SET);
    repeat (5) send_item(CMD_KEY, KEY_NEXT);
    // month, day, hour and minute wrap both ways, year steps up and back
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_NEXT);
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_NEXT);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_NEXT);
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_NEXT);
    send_item(CMD_KEY, KEY_DOWN);
    send_item(CMD_KEY, KEY_UP);
    // clock frozen while setting, spare keys ignored
    send_item(CMD_TICK, KEY_NONE);
    send_item(CMD_KEY, KEY_NONE);
    send_item(CMD_KEY, KEY_SPARE6);
    send_item(CMD_KEY, KEY_SET);
  endtask

  task automatic test_calendar_edges();
    set_ticks_per_second(8'd1);
    // last minute of the year, then on into the next year
    set_clock(12, 31, 2019, 23, 59);
    select_field(MODE_YEAR);
    send_item(CMD_KEY, KEY_UP);
    send_item(CMD_KEY, KEY_DOWN);
    leave_setting();
    tick_past_minute();
    // leap day and on to march
    set_clock(2, 1, 2020, 23, 59);
    set_clock(2, 29, 2020, 23, 59);
    tick_past_minute();
    // leap day made invalid by leaving the leap year
    set_clock(2, 29, 2020, 12, 0);
    set_clock(2, 29, 2021, 12, 0);
    // day beyond a shorter month
    set_clock(1, 31, 2021, 12, 0);
    select_field(MODE_MONTH);
    send_item(CMD_KEY, KEY_UP);
    leave_setting();
  endtask

  task automatic test_output_stall();
    int saved_pct;
    saved_pct = send_idle_pct;
    send_idle_pct = 0;
    stall_req <= ~stall_req;
    repeat (40) send_item(1'($urandom_range(0, 1)), any_key());
    send_idle_pct = saved_pct;
  endtask

  task automatic setting_session();
    int n;
    n = $urandom_range(3, 20);
    if (cal_mode == MODE_RUN) send_item(CMD_KEY, KEY_SET);
    repeat (n) begin
      if ($urandom_range(7) == 0) send_item(CMD_TICK, any_key());
      else send_item(CMD_KEY, pick_setting_key());
    end
    if ($urandom_range(3) != 0) leave_setting();
  endtask

  // set up just before an hour, day, month or year boundary and tick over it
  task automatic rollover_session();
    int kind;
    int month;
    int day;
    int year;
    if (cal_tps > 3) set_ticks_per_second(8'($urandom_range(1, 2)));
    kind  = $urandom_range(3);
    month = (kind == 3) ? 12 : (($urandom_range(3) == 0) ? 2 : $urandom_range(1, 12));
    day   = (kind >= 2) ? 31 : $urandom_range(1, 31);
    year  = (cal_year + 9998 + $urandom_range(0, 4)) % 10000;
    set_clock(month, day, year, (kind == 0) ? $urandom_range(0, 23) : 23, 59);
    tick_past_minute();
    repeat ($urandom_range(0, 5)) send_item(CMD_TICK, any_key());
  endtask

  task automatic run_random_phase(input int n);
    int stop_at;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(4) == 0) set_ticks_per_second(pick_tps());
      case ($urandom_range(9))
        0, 1, 2: repeat ($urandom_range(1, 40)) send_item(CMD_TICK, any_key());
        3, 4, 5: setting_session();
        6, 7: rollover_session();
        default: repeat ($urandom_range(1, 15)) send_item(1'($urandom_range(0, 1)), any_key());
      endcase
    end
  endtask

  initial begin
    send_idle_pct = 6;
    recv_idle_pct = 80;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_keys_while_running();
    test_second_boundary();
    test_field_stepping();
    test_calendar_edges();
    run_random_phase(350);

    send_idle_pct = 80;
    recv_idle_pct = 6;
    test_output_stall();
    run_random_phase(350);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_phase(400);

    // drain and let the pipeline settle
    s_tvalid <= 1'b0;
    while (view_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (view_q.size() != 0) flag_error("expected results left over");

    $display("%0d items sent (%0d ticks, %0d keys), %0d results compared, %0d rate writes",
             items_sent, tick_items, key_items, results_checked, cfg_writes);
    $display("covered field wraps, year rollover, leap day, day clamp, output stall");
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
